// ----- src/fmpc_pkg.sv -----
`default_nettype none

package fmpc_pkg;

	localparam int MAX_RULES = 64;
	localparam int IDX_W     = $clog2(MAX_RULES);
	localparam int CNT_W     = 7;
	localparam int ADDR_W    = 32;
	localparam int LEN_W     = 6;
	localparam int PROTO_W   = 9;
	localparam int PORT_W    = 16;
	localparam int RPORT_W   = 11;

	localparam logic [LEN_W-1:0]   MAX_PREFIX = LEN_W'(32);
	localparam logic [PROTO_W-1:0] PROTO_ANY  = PROTO_W'(256);
	localparam logic [PROTO_W-1:0] PROTO_TCP  = PROTO_W'(6);
	localparam logic [PROTO_W-1:0] PROTO_UDP  = PROTO_W'(17);
	localparam logic [PORT_W-1:0]  PORT_HIGH  = PORT_W'(1024);
	localparam logic [PORT_W-1:0]  PORT_LAST  = PORT_W'(1023);

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_CHECK = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_RESULT
	} state_t;

	// One stored rule; ports fit in 11 bits since writes above 1024 are refused.
	typedef struct packed {
		logic [ADDR_W-1:0]  src_addr;
		logic [LEN_W-1:0]   src_len;
		logic [ADDR_W-1:0]  dst_addr;
		logic [LEN_W-1:0]   dst_len;
		logic [PROTO_W-1:0] proto;
		logic [RPORT_W-1:0] sport;
		logic [RPORT_W-1:0] dport;
		logic [1:0]         ack;
		logic [1:0]         dir;
		logic               action;
	} rule_t;

	typedef struct packed {
		logic [ADDR_W-1:0]  src_addr;
		logic [ADDR_W-1:0]  dst_addr;
		logic [PROTO_W-1:0] proto;
		logic [PORT_W-1:0]  sport;
		logic [PORT_W-1:0]  dport;
		logic               ack;
		logic [1:0]         dir;
	} packet_t;

	typedef struct packed {
		logic             matched;
		logic             verdict;
		logic [IDX_W-1:0] number;
		logic             write_ok;
	} result_t;

	function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
		logic [ADDR_W-1:0] m;
		if (len == '0) begin
			m = '0;
		end else if (len >= MAX_PREFIX) begin
			m = '1;
		end else begin
			m = {ADDR_W{1'b1}} << (MAX_PREFIX - len);
		end
		return m;
	endfunction

endpackage

`default_nettype wire

// ----- src/fmpc_ram.sv -----
`default_nettype none

module fmpc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] waddr,
	input  wire [WIDTH-1:0]         wdata,
	input  wire                     re,
	input  wire [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- src/fmpc_match.sv -----
`default_nettype none

module fmpc_match import fmpc_pkg::*; (
	input  wire rule_t   rule,
	input  wire packet_t pkt,
	output logic         hit
);

	logic [ADDR_W-1:0] smask;
	logic [ADDR_W-1:0] dmask;
	logic              addr_ok;
	logic              proto_ok;
	logic              sport_ok;
	logic              dport_ok;
	logic              ack_ok;
	logic              l4;

	function automatic logic port_ok(input logic [RPORT_W-1:0] rp,
	                                 input logic [PORT_W-1:0] pp);
		logic [PORT_W-1:0] rpx;
		rpx = PORT_W'(rp);
		return (rpx == '0) || ((rpx == PORT_HIGH) && (pp > PORT_LAST)) || (rpx == pp);
	endfunction

	always_comb begin
		smask    = prefix_mask(rule.src_len);
		dmask    = prefix_mask(rule.dst_len);
		addr_ok  = ((rule.src_addr & smask) == (pkt.src_addr & smask)) &&
		           ((rule.dst_addr & dmask) == (pkt.dst_addr & dmask));
		proto_ok = (rule.proto == PROTO_ANY) || (rule.proto == pkt.proto);
		l4       = (pkt.proto == PROTO_TCP) || (pkt.proto == PROTO_UDP);
		sport_ok = port_ok(rule.sport, pkt.sport);
		dport_ok = port_ok(rule.dport, pkt.dport);
		// ack bit1 allows ACK set, bit0 allows ACK clear
		ack_ok   = pkt.ack ? rule.ack[1] : rule.ack[0];
		hit      = addr_ok && proto_ok && ((rule.dir & pkt.dir) != '0) &&
		           (!l4 || (sport_ok && dport_ok &&
		                    ((pkt.proto != PROTO_TCP) || ack_ok)));
	end

endmodule

`default_nettype wire

// ----- src/first_match_packet_classifier.sv -----
// First-match five-tuple classifier over a table of up to 64 rules.
// Requests enter on in_valid/in_ready with the payload fields; opcode 0
// writes a rule at rule_index (refused with write_ok 0 if a port is above
// 1024 or a prefix above 32), opcode 1 checks a packet.  Every request gives
// exactly one result on out_valid/out_ready.
// cfg_we/cfg_wdata set rule_count, the number of rules scanned from entry 0
// (values above 64 scan all 64); write it only while the block is idle.
// For a write, the sequencer passes from idle to its result state, which
// loads the output register.  A check reads one rule per cycle from the
// rule RAM and stops at the first hit or after the last scanned rule; with
// rule_count 0 it goes straight to the result state.  One request is in
// work at a time; the next one is accepted only after a result is loaded
// and the sequencer is idle again.  in_ready is high while the sequencer is
// idle, even when a finished result still waits in the output register.  A
// stalled receiver holds the result and the next request waits for that
// register before finishing.
// Reset clears rule_count, the sequencer and out_valid; the rule
// table is not cleared and must be written before it is scanned.
`default_nettype none

module first_match_packet_classifier import fmpc_pkg::*; (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_ready,
	input  wire                opcode,
	input  wire [IDX_W-1:0]    rule_index,
	input  wire [ADDR_W-1:0]   src_addr,
	input  wire [ADDR_W-1:0]   dst_addr,
	input  wire [LEN_W-1:0]    src_prefix_len,
	input  wire [LEN_W-1:0]    dst_prefix_len,
	input  wire [PROTO_W-1:0]  protocol_code,
	input  wire [PORT_W-1:0]   sport_num,
	input  wire [PORT_W-1:0]   dport_num,
	input  wire [1:0]          ack_code,
	input  wire [1:0]          direction_code,
	input  wire                rule_action,
	output logic               out_valid,
	input  wire                out_ready,
	output logic               matched,
	output logic               verdict,
	output logic [IDX_W-1:0]   rule_number,
	output logic               write_ok,
	input  wire                cfg_we,
	input  wire [CNT_W-1:0]    cfg_wdata
);

	state_t            state_q, state_d;
	logic [CNT_W-1:0]  rule_count_q;
	logic [CNT_W-1:0]  n_rules;
	logic [CNT_W-1:0]  rd_idx_q;
	logic              vld_s1;
	logic [IDX_W-1:0]  idx_s1;
	packet_t           pkt_q;
	result_t           res_q;
	result_t           out_q;
	logic              out_valid_q;
	rule_t             wr_rule;
	rule_t             rd_rule;
	logic              wr_ok;
	logic              in_acc;
	logic              is_check;
	logic              issue;
	logic              hit;
	logic              last_s1;
	logic              finish;
	logic              out_load;

	assign in_acc   = in_valid && in_ready;
	assign is_check = (opcode_t'(opcode) == OP_CHECK);
	assign n_rules  = (rule_count_q > CNT_W'(MAX_RULES)) ? CNT_W'(MAX_RULES) : rule_count_q;

	always_comb begin
		wr_rule.src_addr = src_addr;
		wr_rule.src_len  = src_prefix_len;
		wr_rule.dst_addr = dst_addr;
		wr_rule.dst_len  = dst_prefix_len;
		wr_rule.proto    = protocol_code;
		wr_rule.sport    = sport_num[RPORT_W-1:0];
		wr_rule.dport    = dport_num[RPORT_W-1:0];
		wr_rule.ack      = ack_code;
		wr_rule.dir      = direction_code;
		wr_rule.action   = rule_action;
		wr_ok = (int'(rule_index) < MAX_RULES) &&
		        (src_prefix_len <= MAX_PREFIX) && (dst_prefix_len <= MAX_PREFIX) &&
		        (sport_num <= PORT_HIGH) && (dport_num <= PORT_HIGH);
	end

	fmpc_ram #(
		.WIDTH($bits(rule_t)),
		.DEPTH(MAX_RULES)
	) u_rules (
		.clk  (clk),
		.we   (in_acc && !is_check && wr_ok),
		.waddr(rule_index),
		.wdata(wr_rule),
		.re   (issue),
		.raddr(rd_idx_q[IDX_W-1:0]),
		.rdata(rd_rule)
	);

	fmpc_match u_match (
		.rule(rd_rule),
		.pkt (pkt_q),
		.hit (hit)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					state_d = (is_check && (n_rules != '0)) ? ST_SCAN : ST_RESULT;
				end
			end
			ST_SCAN: begin
				if (finish) begin
					state_d = ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		in_ready = (state_q == ST_IDLE);
		issue    = (state_q == ST_SCAN) && (rd_idx_q < n_rules);
		last_s1  = ((CNT_W'(idx_s1) + CNT_W'(1)) == n_rules);
		finish   = (state_q == ST_SCAN) && vld_s1 && (hit || last_s1);
		out_load = (state_q == ST_RESULT) && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			rule_count_q <= '0;
			rd_idx_q     <= '0;
			vld_s1       <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				rule_count_q <= cfg_wdata;
			end
			if (in_acc) begin
				rd_idx_q <= '0;
			end else if (issue) begin
				rd_idx_q <= rd_idx_q + CNT_W'(1);
			end
			// drop the read already in flight once the scan is decided
			vld_s1 <= issue && !finish;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= rd_idx_q[IDX_W-1:0];
		if (in_acc) begin
			pkt_q.src_addr <= src_addr;
			pkt_q.dst_addr <= dst_addr;
			pkt_q.proto    <= protocol_code;
			pkt_q.sport    <= sport_num;
			pkt_q.dport    <= dport_num;
			pkt_q.ack      <= ack_code[0];
			pkt_q.dir      <= direction_code;
			res_q          <= '{matched: 1'b0, verdict: 1'b0, number: '0,
			                    write_ok: (!is_check && wr_ok)};
		end else if (finish) begin
			res_q.matched <= hit;
			res_q.verdict <= hit && rd_rule.action;
			res_q.number  <= hit ? idx_s1 : '0;
		end
		if (out_load) begin
			out_q <= res_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign matched     = out_q.matched;
	assign verdict     = out_q.verdict;
	assign rule_number = out_q.number;
	assign write_ok    = out_q.write_ok;

endmodule

`default_nettype wire

// ----- bench/first_match_packet_classifier_test.sv -----
`timescale 1ns / 100ps

module first_match_packet_classifier_test;
	import fmpc_pkg::*;

	localparam int LIMIT     = 1_000_000;
	localparam int TAIL      = 80;
	localparam int LONG_HOLD = 300;
	localparam int PHASES    = 10;
	localparam int PER_PHASE = 100;

	typedef struct packed {
		opcode_t            op;
		logic [IDX_W-1:0]   index;
		logic [ADDR_W-1:0]  src;
		logic [ADDR_W-1:0]  dst;
		logic [LEN_W-1:0]   src_len;
		logic [LEN_W-1:0]   dst_len;
		logic [PROTO_W-1:0] proto;
		logic [PORT_W-1:0]  sport;
		logic [PORT_W-1:0]  dport;
		logic [1:0]         ack;
		logic [1:0]         dir;
		logic               action;
	} request_t;

	// Tracks the rule table and rule count, predicts each verdict, and
	// compares the block's results against the queue of predictions.
	class verdict_board;
		rule_t       rules[MAX_RULES];
		int unsigned scan_count;
		result_t     awaited[$];
		int          errors;

		function new();
			scan_count = 0;
			errors = 0;
		endfunction

		function void set_rule_count(logic [CNT_W-1:0] v);
			scan_count = (v > MAX_RULES) ? MAX_RULES : v;
		endfunction

		function bit port_fits(logic [RPORT_W-1:0] rp, logic [PORT_W-1:0] pp);
			if (rp == 0)
				return 1'b1;
			if (rp == PORT_HIGH && pp > PORT_LAST)
				return 1'b1;
			return rp == pp;
		endfunction

		function bit rule_hits(rule_t r, request_t p);
			logic [ADDR_W-1:0] smask;
			logic [ADDR_W-1:0] dmask;
			smask = ~({ADDR_W{1'b1}} >> r.src_len);
			dmask = ~({ADDR_W{1'b1}} >> r.dst_len);
			if ((r.src_addr & smask) != (p.src & smask))
				return 1'b0;
			if ((r.dst_addr & dmask) != (p.dst & dmask))
				return 1'b0;
			if (r.proto != PROTO_ANY && r.proto != p.proto)
				return 1'b0;
			if (p.proto == PROTO_TCP || p.proto == PROTO_UDP) begin
				if (!port_fits(r.sport, p.sport) || !port_fits(r.dport, p.dport))
					return 1'b0;
				if (p.proto == PROTO_TCP && (r.ack & (p.ack[0] ? 2'b10 : 2'b01)) == 2'b00)
					return 1'b0;
			end
			return (r.dir & p.dir) != 2'b00;
		endfunction

		function void note_request(request_t q);
			result_t res;
			rule_t   r;
			int      i;
			res = '0;
			if (q.op == OP_WRITE) begin
				if (q.src_len <= MAX_PREFIX && q.dst_len <= MAX_PREFIX &&
				    q.sport <= PORT_HIGH && q.dport <= PORT_HIGH) begin
					r.src_addr = q.src;
					r.src_len  = q.src_len;
					r.dst_addr = q.dst;
					r.dst_len  = q.dst_len;
					r.proto    = q.proto;
					r.sport    = q.sport[RPORT_W-1:0];
					r.dport    = q.dport[RPORT_W-1:0];
					r.ack      = q.ack;
					r.dir      = q.dir;
					r.action   = q.action;
					rules[q.index] = r;
					res.write_ok = 1'b1;
				end
			end else begin
				for (i = 0; i < scan_count && !res.matched; i++) begin
					if (rule_hits(rules[i], q)) begin
						res.matched = 1'b1;
						res.verdict = rules[i].action;
						res.number  = IDX_W'(i);
					end
				end
			end
			awaited.push_back(res);
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (awaited.size() == 0) begin
				$error("result with no request outstanding: matched %0d verdict %0d rule %0d write_ok %0d",
				       got.matched, got.verdict, got.number, got.write_ok);
				errors++;
				return;
			end
			want = awaited.pop_front();
			if (got.matched !== want.matched) begin
				$error("matched: expected %0d, got %0d", want.matched, got.matched);
				errors++;
			end
			if (got.verdict !== want.verdict) begin
				$error("verdict: expected %0d, got %0d", want.verdict, got.verdict);
				errors++;
			end
			if (got.number !== want.number) begin
				$error("rule_number: expected %0d, got %0d", want.number, got.number);
				errors++;
			end
			if (got.write_ok !== want.write_ok) begin
				$error("write_ok: expected %0d, got %0d", want.write_ok, got.write_ok);
				errors++;
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic               opcode;
	logic [IDX_W-1:0]   rule_index;
	logic [ADDR_W-1:0]  src_addr;
	logic [ADDR_W-1:0]  dst_addr;
	logic [LEN_W-1:0]   src_prefix_len;
	logic [LEN_W-1:0]   dst_prefix_len;
	logic [PROTO_W-1:0] protocol_code;
	logic [PORT_W-1:0]  sport_num;
	logic [PORT_W-1:0]  dport_num;
	logic [1:0]         ack_code;
	logic [1:0]         direction_code;
	logic               rule_action;
	logic               out_valid;
	logic               out_ready;
	logic               matched;
	logic               verdict;
	logic [IDX_W-1:0]   rule_number;
	logic               write_ok;
	logic               cfg_we;
	logic [CNT_W-1:0]   cfg_wdata;

	verdict_board board = new();
	int cycle_count = 0;
	bit quiet_in = 1'b0;
	bit quiet_out = 1'b0;
	bit hold_request = 1'b0;

	first_match_packet_classifier dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.opcode         (opcode),
		.rule_index     (rule_index),
		.src_addr       (src_addr),
		.dst_addr       (dst_addr),
		.src_prefix_len (src_prefix_len),
		.dst_prefix_len (dst_prefix_len),
		.protocol_code  (protocol_code),
		.sport_num      (sport_num),
		.dport_num      (dport_num),
		.ack_code       (ack_code),
		.direction_code (direction_code),
		.rule_action    (rule_action),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.matched        (matched),
		.verdict        (verdict),
		.rule_number    (rule_number),
		.write_ok       (write_ok),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT) begin
			$display("first_match_packet_classifier_test NOT OK");
			$finish;
		end
	end

	// Mostly short idles, a few long ones.
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return $urandom_range(1, 3);
		if (r < 92)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic int in_gap();
		if (quiet_in || $urandom_range(0, 1) == 0)
			return 0;
		return idle_len();
	endfunction

	function automatic request_t make_req(opcode_t op, int idx, logic [ADDR_W-1:0] src,
	                                      int slen, logic [ADDR_W-1:0] dst, int dlen,
	                                      int proto, int sport, int dport, int ack,
	                                      int dir, int act);
		request_t q;
		q.op      = op;
		q.index   = IDX_W'(idx);
		q.src     = src;
		q.dst     = dst;
		q.src_len = LEN_W'(slen);
		q.dst_len = LEN_W'(dlen);
		q.proto   = PROTO_W'(proto);
		q.sport   = PORT_W'(sport);
		q.dport   = PORT_W'(dport);
		q.ack     = 2'(ack);
		q.dir     = 2'(dir);
		q.action  = 1'(act);
		return q;
	endfunction

	function automatic int pick_len();
		case ($urandom_range(0, 5))
			0: return 0;
			1: return 8;
			2: return 16;
			3: return 24;
			4: return 32;
			default: return $urandom_range(0, 32);
		endcase
	endfunction

	function automatic int pick_rule_port();
		case ($urandom_range(0, 3))
			0: return 0;
			1: return PORT_HIGH;
			2: return $urandom_range(1, 1023);
			default: return $urandom_range(0, 1024);
		endcase
	endfunction

	function automatic request_t random_rule(bit allow_bad);
		request_t q;
		q = '0;
		q.op      = OP_WRITE;
		q.index   = IDX_W'($urandom_range(0, MAX_RULES - 1));
		q.src     = $urandom;
		q.dst     = $urandom;
		q.src_len = LEN_W'(pick_len());
		q.dst_len = LEN_W'(pick_len());
		case ($urandom_range(0, 9))
			0, 1, 2: q.proto = PROTO_TCP;
			3, 4, 5: q.proto = PROTO_UDP;
			6, 7:    q.proto = PROTO_ANY;
			8:       q.proto = PROTO_W'($urandom_range(0, 255));
			default: q.proto = PROTO_W'($urandom_range(0, 511));
		endcase
		q.sport  = PORT_W'(pick_rule_port());
		q.dport  = PORT_W'(pick_rule_port());
		q.ack    = 2'($urandom_range(0, 3));
		q.dir    = ($urandom_range(0, 9) == 0) ? 2'b00 : 2'($urandom_range(1, 3));
		q.action = 1'($urandom_range(0, 1));
		// corrupt one field so the write is refused
		if (allow_bad && $urandom_range(0, 7) == 0) begin
			case ($urandom_range(0, 3))
				0: q.src_len = LEN_W'($urandom_range(33, 63));
				1: q.dst_len = LEN_W'($urandom_range(33, 63));
				2: q.sport = PORT_W'($urandom_range(1025, 65535));
				default: q.dport = PORT_W'($urandom_range(1025, 65535));
			endcase
		end
		return q;
	endfunction

	function automatic request_t noise_check();
		request_t q;
		q.op      = OP_CHECK;
		q.index   = IDX_W'($urandom);
		q.src     = $urandom;
		q.dst     = $urandom;
		q.src_len = LEN_W'($urandom);
		q.dst_len = LEN_W'($urandom);
		q.proto   = PROTO_W'($urandom_range(0, 511));
		q.sport   = PORT_W'($urandom_range(0, 65535));
		q.dport   = PORT_W'($urandom_range(0, 65535));
		q.ack     = 2'($urandom_range(0, 3));
		q.dir     = 2'($urandom_range(0, 3));
		q.action  = 1'($urandom);
		return q;
	endfunction

	function automatic logic [PORT_W-1:0] aim_port(logic [RPORT_W-1:0] rp);
		if (rp == 0)
			return PORT_W'($urandom_range(0, 65535));
		if (rp == PORT_HIGH)
			return PORT_W'($urandom_range(1024, 65535));
		return PORT_W'(rp);
	endfunction

	// Build a packet that fits a rule in the scanned range, then maybe spoil it.
	function automatic request_t aimed_check();
		request_t          q;
		rule_t             r;
		logic [ADDR_W-1:0] m;
		q = noise_check();
		if (board.scan_count == 0)
			return q;
		r = board.rules[$urandom_range(0, board.scan_count - 1)];
		m = ~({ADDR_W{1'b1}} >> r.src_len);
		q.src = (r.src_addr & m) | (q.src & ~m);
		m = ~({ADDR_W{1'b1}} >> r.dst_len);
		q.dst = (r.dst_addr & m) | (q.dst & ~m);
		if (r.proto != PROTO_ANY) begin
			q.proto = r.proto;
		end else begin
			case ($urandom_range(0, 3))
				0: q.proto = PROTO_TCP;
				1: q.proto = PROTO_UDP;
				2: q.proto = PROTO_W'($urandom_range(0, 255));
				default: q.proto = PROTO_W'($urandom_range(256, 511));
			endcase
		end
		q.sport = aim_port(r.sport);
		q.dport = aim_port(r.dport);
		if (r.ack == 2'b10)
			q.ack[0] = 1'b1;
		else if (r.ack == 2'b01)
			q.ack[0] = 1'b0;
		case (r.dir)
			2'b01: q.dir = ($urandom_range(0, 3) == 0) ? 2'b11 : 2'b01;
			2'b10: q.dir = ($urandom_range(0, 3) == 0) ? 2'b11 : 2'b10;
			2'b11: q.dir = 2'($urandom_range(1, 3));
			default: ;
		endcase
		if ($urandom_range(0, 3) == 0) begin
			case ($urandom_range(0, 5))
				0: q.src = q.src ^ (32'h1 << $urandom_range(0, 31));
				1: q.dst = q.dst ^ (32'h1 << $urandom_range(0, 31));
				2: q.proto = PROTO_W'($urandom_range(0, 511));
				3: q.dport = PORT_W'($urandom_range(0, 65535));
				4: q.ack[0] = ~q.ack[0];
				default: q.dir = 2'b00;
			endcase
		end
		return q;
	endfunction

	task automatic send_request(request_t q, int gap);
		in_valid       <= 1'b1;
		opcode         <= q.op;
		rule_index     <= q.index;
		src_addr       <= q.src;
		dst_addr       <= q.dst;
		src_prefix_len <= q.src_len;
		dst_prefix_len <= q.dst_len;
		protocol_code  <= q.proto;
		sport_num      <= q.sport;
		dport_num      <= q.dport;
		ack_code       <= q.ack;
		direction_code <= q.dir;
		rule_action    <= q.action;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		board.note_request(q);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (board.awaited.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_rule_count(int v);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= CNT_W'(v);
		@(posedge clk);
		cfg_we <= 1'b0;
		board.set_rule_count(CNT_W'(v));
	endtask

	// Result side: random stalls, plus one long hold on request.
	initial begin
		int stall_left;
		int hold_left;
		stall_left = 0;
		hold_left = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				board.check_result({matched, verdict, rule_number, write_ok});
			if (hold_request) begin
				hold_left = LONG_HOLD;
				hold_request = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (!quiet_out && $urandom_range(0, 3) == 0)
					stall_left = idle_len();
			end
		end
	end

	initial begin
		int phase_counts[PHASES];
		int p;
		int k;
		int r;
		request_t q;
		phase_counts = '{64, 1, 127, 8, 0, 40, 64, 3, 100, 20};
		arst_n         <= 1'b0;
		in_valid       <= 1'b0;
		opcode         <= OP_WRITE;
		rule_index     <= '0;
		src_addr       <= '0;
		dst_addr       <= '0;
		src_prefix_len <= '0;
		dst_prefix_len <= '0;
		protocol_code  <= '0;
		sport_num      <= '0;
		dport_num      <= '0;
		ack_code       <= '0;
		direction_code <= '0;
		rule_action    <= 1'b0;
		cfg_we         <= 1'b0;
		cfg_wdata      <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty scan, then refused and accepted writes at the field extremes
		send_request(make_req(OP_CHECK, 63, '1, 63, '1, 63, 511, 65535, 65535, 3, 3, 1),
		             in_gap());
		send_request(make_req(OP_CHECK, 0, '0, 0, '0, 0, 0, 0, 0, 0, 0, 0), in_gap());
		send_request(make_req(OP_WRITE, 63, '1, 32, '1, 32, 511, 1024, 1024, 3, 3, 1),
		             in_gap());
		send_request(make_req(OP_WRITE, 0, '1, 33, 0, 0, 6, 0, 0, 3, 3, 1), in_gap());
		send_request(make_req(OP_WRITE, 0, 0, 0, '1, 63, 6, 0, 0, 3, 3, 1), in_gap());
		send_request(make_req(OP_WRITE, 0, 0, 0, 0, 0, 17, 1025, 0, 3, 3, 1), in_gap());
		send_request(make_req(OP_WRITE, 0, 0, 0, 0, 0, 17, 0, 65535, 3, 3, 1), in_gap());
		send_request(make_req(OP_WRITE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), in_gap());

		// fill the whole table so any rule count is safe to scan
		for (k = 0; k < MAX_RULES; k++) begin
			q = random_rule(1'b0);
			q.index = IDX_W'(k);
			send_request(q, in_gap());
		end

		write_rule_count(8);
		send_request(make_req(OP_WRITE, 0, 32'h0A000000, 8, 0, 0, 6, 0, 80, 2, 1, 1), 0);
		send_request(make_req(OP_WRITE, 1, 0, 0, 0, 0, 17, 1024, 53, 0, 2, 0), 0);
		send_request(make_req(OP_WRITE, 2, 0, 0, 0, 0, 300, 0, 0, 0, 3, 1), 0);
		send_request(make_req(OP_WRITE, 3, 0, 0, 0, 0, 6, 0, 0, 1, 3, 0), 0);
		send_request(make_req(OP_WRITE, 4, 0, 0, 32'hC0A80100, 24, 1, 1000, 1024, 0, 1, 1), 0);
		send_request(make_req(OP_WRITE, 5, 0, 0, 0, 0, 17, 0, 0, 3, 0, 1), 0);
		send_request(make_req(OP_WRITE, 6, '1, 32, 0, 0, 256, 0, 0, 0, 2, 0), 0);
		send_request(make_req(OP_WRITE, 7, 0, 0, 0, 0, 256, 0, 0, 3, 3, 1), 0);
		send_request(make_req(OP_CHECK, 0, 32'h0A010203, 0, 1, 0, 6, 5000, 80, 1, 1, 0), 1);
		send_request(make_req(OP_CHECK, 0, 32'h0A010203, 0, 1, 0, 6, 5000, 80, 0, 1, 0), 1);
		send_request(make_req(OP_CHECK, 0, 32'h0A010203, 0, 1, 0, 6, 5000, 80, 2, 1, 0), 1);
		send_request(make_req(OP_CHECK, 0, 7, 0, 9, 0, 17, 1023, 53, 0, 2, 0), 0);
		send_request(make_req(OP_CHECK, 0, 7, 0, 9, 0, 17, 1024, 53, 0, 2, 0), 0);
		send_request(make_req(OP_CHECK, 0, 7, 0, 9, 0, 17, 65535, 53, 0, 2, 0), 0);
		send_request(make_req(OP_CHECK, 0, 7, 0, 9, 0, 300, 0, 0, 0, 1, 0), 2);
		send_request(make_req(OP_CHECK, 0, 7, 0, 32'hC0A8014D, 0, 1, 0, 0, 0, 1, 0), 2);
		send_request(make_req(OP_CHECK, 0, 7, 0, 9, 0, 6, 1, 1, 1, 0, 0), 0);
		send_request(make_req(OP_CHECK, 0, '1, 0, 9, 0, 50, 0, 0, 0, 2, 0), 0);
		send_request(make_req(OP_CHECK, 0, 7, 0, 9, 0, 2, 0, 0, 0, 3, 0), 0);

		for (p = 0; p < PHASES; p++) begin
			write_rule_count(phase_counts[p]);
			quiet_in  = (p == 3);
			quiet_out = (p == 3 || p == 7);
			if (p == 1)
				hold_request = 1'b1;
			for (k = 0; k < PER_PHASE; k++) begin
				if (p == 5 && k == PER_PHASE / 2)
					drain();
				r = $urandom_range(0, 99);
				if (r < 20)
					q = random_rule(1'b1);
				else if (r < 85)
					q = aimed_check();
				else
					q = noise_check();
				send_request(q, in_gap());
			end
		end

		drain();
		repeat (TAIL) @(posedge clk);
		if (board.errors == 0 && board.awaited.size() == 0)
			$display("first_match_packet_classifier_test OK");
		else
			$display("first_match_packet_classifier_test NOT OK");
		$finish;
	end

endmodule

// ----- first_match_packet_classifier.f -----
src/fmpc_pkg.sv
src/fmpc_ram.sv
src/fmpc_match.sv
src/first_match_packet_classifier.sv
bench/first_match_packet_classifier_test.sv
